>>> sv/multipart_reassembler_unit_assert.svh
// Assertion macros shared by the multipart reassembler RTL
`ifndef MULTIPART_REASSEMBLER_UNIT_ASSERT_SVH
`define MULTIPART_REASSEMBLER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define MRU_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked at the next rising clock edge
`define MRU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mru_pkg.sv
// Types and constants of the multipart reassembler
package mru_pkg;

  localparam int MAX_MESSAGE   = 4096;
  localparam int CHUNK_BYTES   = 27;
  localparam int ADDR_W        = $clog2(MAX_MESSAGE);
  localparam int LEN_W         = $clog2(MAX_MESSAGE + 1);
  localparam int SEG_W         = 16;
  localparam int BIDX_W        = 5;
  localparam int CSZ_W         = $clog2(CHUNK_BYTES + 1);
  localparam int OFF_W         = SEG_W + CSZ_W;
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(2000);

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_CHUNK  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_NO_MSG    = 3'd1,
    ST_BEYOND    = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_COMPLETE  = 3'd5,
    ST_READ_DATA = 3'd6
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = CFG_IDX_W'(1);

  // Result held in the output stage; the read byte joins from the store
  typedef struct packed {
    status_t          status;
    logic             message_done;
    logic [7:0]       done_source;
    logic [7:0]       done_target;
    logic [15:0]      done_type;
    logic [LEN_W-1:0] done_length;
    logic             receiving;
    logic             is_read;
  } res_t;

endpackage

>>> sv/mru_in_if.sv
// Input item channel of the multipart reassembler
interface mru_in_if;
  import mru_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [7:0]        sender;
  logic [SEG_W-1:0]  segment_id;
  logic [BIDX_W-1:0] byte_index;
  logic [7:0]        data_byte;
  logic              chunk_end;
  logic [15:0]       total_size;
  logic [15:0]       message_type;
  logic [ADDR_W-1:0] read_address;

  modport source (
    output valid, cmd, sender, segment_id, byte_index, data_byte, chunk_end,
           total_size, message_type, read_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, sender, segment_id, byte_index, data_byte, chunk_end,
           total_size, message_type, read_address,
    output ready
  );
endinterface

>>> sv/mru_out_if.sv
// Result item channel of the multipart reassembler
interface mru_out_if;
  import mru_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             message_done;
  logic [7:0]       done_source;
  logic [7:0]       done_target;
  logic [15:0]      done_type;
  logic [LEN_W-1:0] done_length;
  logic [7:0]       read_byte;
  logic             receiving;

  modport source (
    output valid, status, message_done, done_source, done_target, done_type,
           done_length, read_byte, receiving,
    input  ready
  );
  modport sink (
    input  valid, status, message_done, done_source, done_target, done_type,
           done_length, read_byte, receiving,
    output ready
  );
endinterface

>>> sv/mru_ram.sv
// Generic single-port-write, registered-read RAM
module mru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/multipart_reassembler_unit.sv
// Multipart message reassembler: header/chunk/tick/read items in, one result per item
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   in_ch    | in  | valid/ready   | cmd, sender, segment, byte, sizes, address
//   out_ch   | out | valid/ready   | status, completion details, read byte
//   cfg      | in  | cfg_we        | cfg_index, cfg_data (node address, timeout)
//
// One item per cycle while the output is not stalled: every item is decided in the
// cycle it is accepted and its result sits in the output register in the next cycle;
// read data comes from the store's registered read port in that same cycle.
// The store takes one write (chunk byte) or one read per item.
// Reset is synchronous and clears the message state; the store is not cleared.
// An output stall holds the result and the store read data, and blocks input.
module multipart_reassembler_unit (
  input  logic                           clk,
  input  logic                           rst,
  mru_in_if.sink                         in_ch,
  mru_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mru_pkg::*;

  `include "multipart_reassembler_unit_assert.svh"

  // Configuration
  logic [7:0]        own_node_address;
  logic [TICK_W-1:0] timeout_ticks;

  // Message state
  logic              open_flag,       open_flag_next;
  logic [LEN_W-1:0]  expected_length, expected_length_next;
  logic [LEN_W-1:0]  received_count,  received_count_next;
  logic [7:0]        open_sender,     open_sender_next;
  logic [15:0]       open_type,       open_type_next;
  logic [TICK_W-1:0] idle_ticks,      idle_ticks_next;

  // Output stage
  logic s1_valid;
  res_t s1,  s1_next;

  // Store access
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [7:0]        mem_rdata;

  // Chunk placement
  logic              in_fire;
  cmd_t              cmd;
  logic [SEG_W-1:0]  seg_m1;
  logic [OFF_W-1:0]  offset;
  logic              offset_ok;
  logic [LEN_W-1:0]  remain;
  logic [CSZ_W-1:0]  csize;
  logic [LEN_W-1:0]  count_sum;
  logic [TICK_W-1:0] idle_inc;

  assign in_ch.ready = !s1_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  assign seg_m1    = in_ch.segment_id - SEG_W'(1);
  assign offset    = OFF_W'(seg_m1) * OFF_W'(CHUNK_BYTES);
  assign offset_ok = (in_ch.segment_id != '0) && (offset < OFF_W'(expected_length));
  assign remain    = expected_length - offset[LEN_W-1:0];
  assign csize     = (remain > LEN_W'(CHUNK_BYTES)) ? CSZ_W'(CHUNK_BYTES)
                                                    : remain[CSZ_W-1:0];
  assign count_sum = received_count + LEN_W'(csize);
  assign idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + TICK_W'(1);

  assign mem_waddr = offset[ADDR_W-1:0] + ADDR_W'(in_ch.byte_index);
  assign mem_re    = in_fire && (cmd == CMD_READ);

  always_comb begin
    open_flag_next       = open_flag;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    open_sender_next     = open_sender;
    open_type_next       = open_type;
    idle_ticks_next      = idle_ticks;
    mem_we               = 1'b0;

    s1_next              = '0;
    s1_next.status       = ST_ACCEPTED;

    case (cmd)
      CMD_HEADER: begin
        open_flag_next       = 1'b0;
        expected_length_next = '0;
        received_count_next  = '0;
        if (in_ch.total_size > 16'(MAX_MESSAGE)) begin
          s1_next.status = ST_TOO_LARGE;
        end else begin
          open_flag_next       = 1'b1;
          expected_length_next = in_ch.total_size[LEN_W-1:0];
          open_sender_next     = in_ch.sender;
          open_type_next       = in_ch.message_type;
          idle_ticks_next      = '0;
        end
      end
      CMD_CHUNK: begin
        if (!open_flag || in_ch.sender != open_sender) begin
          s1_next.status = ST_NO_MSG;
        end else if (!offset_ok) begin
          s1_next.status = ST_BEYOND;
        end else begin
          idle_ticks_next = '0;
          if (in_ch.byte_index < BIDX_W'(csize)) begin
            mem_we = in_fire;
          end else begin
            s1_next.status = ST_BEYOND;
          end
          if (in_ch.chunk_end) begin
            received_count_next = count_sum;
            if (count_sum >= expected_length) begin
              s1_next.status       = ST_COMPLETE;
              s1_next.message_done = 1'b1;
              s1_next.done_source  = open_sender;
              s1_next.done_target  = own_node_address;
              s1_next.done_type    = open_type;
              s1_next.done_length  = expected_length;
              open_flag_next       = 1'b0;
              expected_length_next = '0;
              received_count_next  = '0;
            end
          end
        end
      end
      CMD_TICK: begin
        idle_ticks_next = idle_inc;
        if (open_flag && idle_inc > timeout_ticks) begin
          open_flag_next       = 1'b0;
          expected_length_next = '0;
          received_count_next  = '0;
          s1_next.status       = ST_TIMEOUT;
        end
      end
      CMD_READ: begin
        s1_next.status  = ST_READ_DATA;
        s1_next.is_read = 1'b1;
      end
      default: begin
        s1_next.status = ST_ACCEPTED;
      end
    endcase

    s1_next.receiving = open_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_address <= '0;
      timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ADDR: own_node_address <= cfg_data[7:0];
        REG_TIMEOUT:  timeout_ticks    <= cfg_data[TICK_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag       <= 1'b0;
      expected_length <= '0;
      received_count  <= '0;
      open_sender     <= '0;
      open_type       <= '0;
      idle_ticks      <= '0;
      s1_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        open_flag       <= open_flag_next;
        expected_length <= expected_length_next;
        received_count  <= received_count_next;
        open_sender     <= open_sender_next;
        open_type       <= open_type_next;
        idle_ticks      <= idle_ticks_next;
        s1_valid        <= 1'b1;
      end else if (out_ch.ready) begin
        s1_valid        <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  mru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MESSAGE)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_ch.data_byte),
    .re    (mem_re),
    .raddr (in_ch.read_address),
    .rdata (mem_rdata)
  );

  assign out_ch.valid        = s1_valid;
  assign out_ch.status       = s1.status;
  assign out_ch.message_done = s1.message_done;
  assign out_ch.done_source  = s1.done_source;
  assign out_ch.done_target  = s1.done_target;
  assign out_ch.done_type    = s1.done_type;
  assign out_ch.done_length  = s1.done_length;
  assign out_ch.read_byte    = s1.is_read ? mem_rdata : 8'h00;
  assign out_ch.receiving    = s1.receiving;

  `MRU_ASSERT_IMPL(a_count_below_len, clk, rst, open_flag,
    received_count < expected_length || received_count == '0,
    "received count reached message length while still open")
  `MRU_ASSERT_IMPL(a_write_on_chunk, clk, rst, mem_we,
    in_fire && cmd == CMD_CHUNK && open_flag,
    "store written outside an accepted chunk item")
  `MRU_ASSERT_IMPL(a_done_status, clk, rst, s1_valid && s1.message_done,
    s1.status == ST_COMPLETE && !s1.receiving,
    "completion flagged without complete status")
  `MRU_ASSERT_NEXT(a_stall_holds, clk, rst, s1_valid && !out_ch.ready,
    s1_valid && $stable(s1.status) && $stable(out_ch.read_byte),
    "stalled result lost or changed")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the multipart message reassembler
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mru_pkg::*;

  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        sender;
    logic [SEG_W-1:0]  segment_id;
    logic [BIDX_W-1:0] byte_index;
    logic [7:0]        data_byte;
    logic              chunk_end;
    logic [15:0]       total_size;
    logic [15:0]       message_type;
    logic [ADDR_W-1:0] read_address;
  } frag_item_t;

  typedef struct packed {
    status_t          status;
    logic             message_done;
    logic [7:0]       done_source;
    logic [7:0]       done_target;
    logic [15:0]      done_type;
    logic [LEN_W-1:0] done_length;
    logic [7:0]       read_byte;
    logic             receiving;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mru_in_if  in_ch ();
  mru_out_if out_ch ();

  multipart_reassembler_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Reassembly state mirrored from the block
  logic [7:0]  node_addr;
  logic [15:0] idle_limit;
  bit          msg_open;
  int unsigned msg_len;
  int unsigned msg_got;
  logic [7:0]  msg_sender;
  logic [15:0] msg_type;
  int unsigned idle_count;
  logic [7:0]  store_bytes [MAX_MESSAGE];
  bit          store_seen [MAX_MESSAGE];
  int unsigned written_addrs [$];

  outcome_t pending_outcomes [$];

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_limit = 6;
  int hold_left = 0;
  bit hold_request = 1'b0;

  always #4 clk = ~clk;

  function automatic outcome_t reassemble_item(frag_item_t it);
    outcome_t    r;
    int unsigned seg;
    int unsigned off;
    int unsigned csize;
    int unsigned addr;
    r = '0;
    r.status = ST_ACCEPTED;
    seg = it.segment_id;
    off = (seg - 1) * CHUNK_BYTES;
    case (it.cmd)
      CMD_HEADER: begin
        msg_open = 1'b0;
        msg_len = 0;
        msg_got = 0;
        if (it.total_size > MAX_MESSAGE) begin
          r.status = ST_TOO_LARGE;
        end else begin
          msg_open = 1'b1;
          msg_len = it.total_size;
          msg_sender = it.sender;
          msg_type = it.message_type;
          idle_count = 0;
        end
      end
      CMD_CHUNK: begin
        if (!msg_open || it.sender != msg_sender) begin
          r.status = ST_NO_MSG;
        end else if (seg == 0 || off >= msg_len) begin
          r.status = ST_BEYOND;
        end else begin
          csize = msg_len - off;
          if (csize > CHUNK_BYTES) csize = CHUNK_BYTES;
          addr = off + it.byte_index;
          if (it.byte_index < csize && addr < MAX_MESSAGE) begin
            store_bytes[addr] = it.data_byte;
            if (!store_seen[addr]) begin
              store_seen[addr] = 1'b1;
              written_addrs.push_back(addr);
            end
          end else begin
            r.status = ST_BEYOND;
          end
          idle_count = 0;
          if (it.chunk_end) begin
            msg_got += csize;
            if (msg_got >= msg_len) begin
              r.status = ST_COMPLETE;
              r.message_done = 1'b1;
              r.done_source = msg_sender;
              r.done_target = node_addr;
              r.done_type = msg_type;
              r.done_length = LEN_W'(msg_len);
              msg_open = 1'b0;
              msg_len = 0;
              msg_got = 0;
            end
          end
        end
      end
      CMD_TICK: begin
        if (idle_count < 65535) idle_count++;
        if (msg_open && idle_count > idle_limit) begin
          msg_open = 1'b0;
          msg_len = 0;
          msg_got = 0;
          r.status = ST_TIMEOUT;
        end
      end
      default: begin
        r.status = ST_READ_DATA;
        r.read_byte = store_bytes[it.read_address];
      end
    endcase
    r.receiving = msg_open;
    return r;
  endfunction

  // Fields that the command does not use carry random values
  function automatic frag_item_t random_item(cmd_t c);
    frag_item_t it;
    it = frag_item_t'(84'({$urandom, $urandom, $urandom}));
    it.byte_index = BIDX_W'($urandom_range(0, CHUNK_BYTES - 1));
    it.cmd = c;
    return it;
  endfunction

  function automatic frag_item_t header_item(logic [7:0] s, int unsigned size, logic [15:0] t);
    frag_item_t it;
    it = random_item(CMD_HEADER);
    it.sender = s;
    it.total_size = 16'(size);
    it.message_type = t;
    return it;
  endfunction

  function automatic frag_item_t chunk_item(logic [7:0] s, int unsigned seg, int unsigned bidx,
                                            logic [7:0] d, bit cend);
    frag_item_t it;
    it = random_item(CMD_CHUNK);
    it.sender = s;
    it.segment_id = SEG_W'(seg);
    it.byte_index = BIDX_W'(bidx);
    it.data_byte = d;
    it.chunk_end = cend;
    return it;
  endfunction

  function automatic frag_item_t read_item(int unsigned addr);
    frag_item_t it;
    it = random_item(CMD_READ);
    it.read_address = ADDR_W'(addr);
    return it;
  endfunction

  function automatic int unsigned any_written_addr();
    return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
  endfunction

  function automatic frag_item_t noise_item();
    frag_item_t  it;
    int unsigned pick;
    int unsigned seg;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it = header_item(8'($urandom), $urandom_range(0, 4200), 16'($urandom));
    end else if (pick < 50) begin
      if ($urandom_range(0, 3) == 0) seg = $urandom_range(0, 65535);
      else seg = $urandom_range(0, msg_len / CHUNK_BYTES + 2);
      it = chunk_item($urandom_range(0, 1) ? msg_sender : 8'($urandom), seg,
                      $urandom_range(0, CHUNK_BYTES - 1), 8'($urandom),
                      1'($urandom_range(0, 1)));
    end else if (pick < 80 || written_addrs.size() == 0) begin
      it = random_item(CMD_TICK);
    end else begin
      it = read_item(any_written_addr());
    end
    return it;
  endfunction

  // Offer one item in bursts with random gaps; predict at acceptance
  task automatic send_item(frag_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_limit == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_limit);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.cmd          <= it.cmd;
    in_ch.sender       <= it.sender;
    in_ch.segment_id   <= it.segment_id;
    in_ch.byte_index   <= it.byte_index;
    in_ch.data_byte    <= it.data_byte;
    in_ch.chunk_end    <= it.chunk_end;
    in_ch.total_size   <= it.total_size;
    in_ch.message_type <= it.message_type;
    in_ch.read_address <= it.read_address;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_outcomes.push_back(reassemble_item(it));
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OWN_ADDR) node_addr = value[7:0];
    else if (idx == REG_TIMEOUT) idle_limit = value;
  endtask

  task automatic noise_burst();
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 6)) send_item(random_item(CMD_TICK));
    end else begin
      repeat ($urandom_range(1, 3)) send_item(noise_item());
    end
  endtask

  // Chunks in order with random content, occasional noise and aborts
  task automatic send_message(int unsigned size);
    logic [7:0]  s;
    int unsigned nseg;
    int unsigned off;
    int unsigned csize;
    s = 8'($urandom);
    send_item(header_item(s, size, 16'($urandom)));
    nseg = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
    for (int unsigned seg = 1; seg <= nseg; seg++) begin
      if ($urandom_range(0, 99) < 2) return;
      off = (seg - 1) * CHUNK_BYTES;
      csize = (size - off > CHUNK_BYTES) ? CHUNK_BYTES : size - off;
      for (int unsigned b = 0; b < csize; b++) begin
        if ($urandom_range(0, 99) < 4) noise_burst();
        // stray byte past the short last chunk, ahead of its closing byte
        if (seg == nseg && b == csize - 1 && csize < CHUNK_BYTES && $urandom_range(0, 9) == 0)
          send_item(chunk_item(s, seg, $urandom_range(csize, CHUNK_BYTES - 1), 8'($urandom), 1'b0));
        send_item(chunk_item(s, seg, b, 8'($urandom), b == csize - 1));
      end
    end
    if ($urandom_range(0, 99) < 30 && written_addrs.size() != 0) begin
      repeat ($urandom_range(1, 3)) send_item(read_item(any_written_addr()));
    end
  endtask

  // Scattered chunks into a large buffer; sometimes closed by repeated chunk ends
  task automatic send_large_message();
    logic [7:0]  s;
    int unsigned size;
    int unsigned nseg;
    int unsigned seg;
    int unsigned nb;
    s = 8'($urandom);
    size = $urandom_range(301, MAX_MESSAGE);
    send_item(header_item(s, size, 16'($urandom)));
    nseg = (size + CHUNK_BYTES - 1) / CHUNK_BYTES;
    repeat ($urandom_range(2, 5)) begin
      seg = $urandom_range(1, nseg);
      nb = $urandom_range(1, 6);
      for (int k = 0; k < nb; k++)
        send_item(chunk_item(s, seg, $urandom_range(0, CHUNK_BYTES - 1), 8'($urandom), k == nb - 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      while (msg_open && msg_sender == s)
        send_item(chunk_item(s, $urandom_range(1, nseg), $urandom_range(0, CHUNK_BYTES - 1),
                             8'($urandom), 1'b1));
    end
  endtask

  task automatic send_random_message();
    int unsigned pick;
    logic [7:0]  s;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_message($urandom_range(1, 60));
    end else if (pick < 78) begin
      send_message($urandom_range(61, 300));
    end else if (pick < 83) begin
      send_message(0);
      if ($urandom_range(0, 1) == 1) send_item(chunk_item(msg_sender, 1, 0, 8'($urandom), 1'b1));
    end else if (pick < 88) begin
      s = 8'($urandom);
      send_item(header_item(s, $urandom_range(MAX_MESSAGE + 1, 65535), 16'($urandom)));
      send_item(chunk_item(s, 1, 0, 8'($urandom), 1'b1));
    end else if (pick < 95) begin
      send_large_message();
    end else begin
      send_message($urandom_range(0, 1) ? 1 : CHUNK_BYTES);
    end
  endtask

  task automatic test_directed();
    send_item(chunk_item(8'h05, 1, 0, 8'h11, 1'b1));
    send_item(random_item(CMD_TICK));
    send_item(header_item(8'h01, MAX_MESSAGE + 1, 16'h0001));
    send_item(header_item(8'h01, 65535, 16'h0001));
    // empty message: nothing can land in it
    send_item(header_item(8'h00, 0, 16'hFFFF));
    send_item(chunk_item(8'h00, 1, 0, 8'h22, 1'b1));
    send_item(header_item(8'hFF, MAX_MESSAGE, 16'h0000));
    send_item(chunk_item(8'hFE, 152, 0, 8'h33, 1'b0));
    send_item(chunk_item(8'hFF, 0, 0, 8'h44, 1'b1));
    send_item(chunk_item(8'hFF, 152, 26, 8'hFF, 1'b0));
    send_item(chunk_item(8'hFF, 152, 18, 8'hA5, 1'b1));
    send_item(chunk_item(8'hFF, 153, 0, 8'h55, 1'b1));
    send_item(chunk_item(8'hFF, 65535, 0, 8'h66, 1'b1));
    send_item(read_item(MAX_MESSAGE - 1));
    send_item(header_item(8'h07, 30, 16'h1234));
    // store keeps its bytes across a new header
    send_item(read_item(MAX_MESSAGE - 1));
    send_item(chunk_item(8'h07, 1, 0, 8'h00, 1'b1));
    send_item(chunk_item(8'h07, 1, 26, 8'h5A, 1'b1));
    send_item(header_item(8'h07, 3, 16'hABCD));
    send_item(chunk_item(8'h07, 1, 10, 8'h77, 1'b1));
    send_item(read_item(26));
    write_register(REG_OWN_ADDR, CFG_DATA_W'(8'hFF));
    write_register(REG_TIMEOUT, CFG_DATA_W'(1));
    send_item(header_item(8'h80, 30, 16'h8001));
    send_item(chunk_item(8'h80, 2, 5, 8'h88, 1'b1));
    send_item(chunk_item(8'h80, 1, 26, 8'h99, 1'b1));
    send_item(header_item(8'h80, 10, 16'h8002));
    send_item(random_item(CMD_TICK));
    send_item(random_item(CMD_TICK));
    send_item(random_item(CMD_TICK));
  endtask

  // Hold the result side while items keep coming, then let everything drain
  task automatic test_backpressure();
    gap_limit = 0;
    hold_request = 1'b1;
    send_message(40);
    wait_for_results();
    gap_limit = 6;
  endtask

  // A large limit keeps the message open; a lower limit then times it out on the next tick
  task automatic test_idle_limit();
    write_register(REG_TIMEOUT, 16'hFFFF);
    gap_limit = 0;
    send_item(header_item(8'h3C, 100, 16'h0F0F));
    repeat (40) send_item(random_item(CMD_TICK));
    write_register(REG_TIMEOUT, 16'd30);
    send_item(random_item(CMD_TICK));
    gap_limit = 6;
  endtask

  task automatic test_random_traffic(logic [7:0] addr, logic [15:0] limit, int count);
    int stop;
    write_register(REG_OWN_ADDR, CFG_DATA_W'(addr));
    write_register(REG_TIMEOUT, limit);
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 85) send_random_message();
      else noise_burst();
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual status %0h",
                 $time, out_ch.status);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("message_done", 32'(want.message_done), 32'(out_ch.message_done));
        check_field("done_source", 32'(want.done_source), 32'(out_ch.done_source));
        check_field("done_target", 32'(want.done_target), 32'(out_ch.done_target));
        check_field("done_type", 32'(want.done_type), 32'(out_ch.done_type));
        check_field("done_length", 32'(want.done_length), 32'(out_ch.done_length));
        check_field("read_byte", 32'(want.read_byte), 32'(out_ch.read_byte));
        check_field("receiving", 32'(want.receiving), 32'(out_ch.receiving));
      end
    end
  end

  // Result side: long hold on request, otherwise stall rate changes in stretches
  initial begin
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 200);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        mode_left--;
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.sender = '0;
    in_ch.segment_id = '0;
    in_ch.byte_index = '0;
    in_ch.data_byte = '0;
    in_ch.chunk_end = 1'b0;
    in_ch.total_size = '0;
    in_ch.message_type = '0;
    in_ch.read_address = '0;
    node_addr = 8'h00;
    idle_limit = TIMEOUT_RESET;
    msg_open = 1'b0;
    msg_len = 0;
    msg_got = 0;
    msg_sender = 8'h00;
    msg_type = 16'h0000;
    idle_count = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_idle_limit();
    test_random_traffic(8'hFF, 16'hFFFF, 300);
    test_random_traffic(8'($urandom), 16'd3, 300);
    test_random_traffic(8'h00, 16'd1, 250);
    test_random_traffic(8'($urandom), 16'd2000, 350);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> multipart_reassembler_unit.f
+incdir+sv
sv/mru_pkg.sv
sv/mru_in_if.sv
sv/mru_out_if.sv
sv/mru_ram.sv
sv/multipart_reassembler_unit.sv
bench/testbench.sv
